### design/asrl_pkg.sv
// Shared types, constants and codes for the address symbol range lookup block.
package asrl_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int ID_BITS       = 16;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int CNT_W         = $clog2(TABLE_ENTRIES + 1);
    localparam int RAM_DEPTH     = 2 * TABLE_ENTRIES;
    localparam int RAM_AW        = IDX_W + 1;
    localparam logic [31:0] REACH_RESET = 32'h0000_1000;

    typedef enum logic [1:0] {
        OP_LOOKUP   = 2'd0,
        OP_INS_MAIN = 2'd1,
        OP_INS_OVL  = 2'd2,
        OP_CLEAR    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_MATCH = 2'd0,
        ST_MISS  = 2'd1,
        ST_DONE  = 2'd2,
        ST_FULL  = 2'd3
    } status_t;

    typedef enum logic {
        REG_OVERLAY_BASE  = 1'b0,
        REG_UNSIZED_REACH = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] address;
        logic [31:0] entry_size;
        logic [15:0] entry_id;
    } request_t;

    typedef struct packed {
        logic [1:0]  status;
        logic        from_overlay;
        logic [15:0] match_id;
        logic [31:0] match_offset;
    } response_t;

    typedef struct packed {
        logic [31:0] overlay_text_base;
        logic [31:0] unsized_reach;
    } cfg_t;

    typedef struct packed {
        logic [31:0]        start;
        logic [31:0]        length;
        logic [ID_BITS-1:0] ident;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic          le;
        logic          hit;
        logic [31:0]   delta;
    } cmp_res_t;

endpackage

### design/asrl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asrl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/asrl_cmp.sv
// Shared compare unit: start against key, and end check (sized) or reach check (unsized) of one table entry.
module asrl_cmp import asrl_pkg::*; (
    input  entry_t      entry,
    input  logic [31:0] key,
    input  logic [31:0] reach,
    output cmp_res_t    res
);

    logic [32:0] end_sum;

    always_comb
    begin
        end_sum   = {1'b0, entry.start} + {1'b0, entry.length};
        res.le    = (entry.start <= key);
        res.delta = key - entry.start;
        if (entry.length != 32'd0)
        begin
            res.hit = ({1'b0, key} < end_sum);
        end
        else
        begin
            res.hit = (res.delta <= reach);
        end
    end

endmodule

### design/asrl_seq.sv
// Sequencer: binary search, entry shifting, table counts and result register.
module asrl_seq import asrl_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  request_t             request,
    input  cfg_t                 cfg,
    output logic                 busy,
    output logic                 done,
    output response_t            response,
    output logic                 ram_we,
    output logic [RAM_AW-1:0]    ram_waddr,
    output entry_t               ram_wdata,
    output logic [RAM_AW-1:0]    ram_raddr,
    input  entry_t               ram_rdata
);

    typedef enum logic [6:0] {
        S_IDLE    = 7'b000_0001,
        S_SRCH    = 7'b000_0010,
        S_CMP     = 7'b000_0100,
        S_CHECK   = 7'b000_1000,
        S_OVL     = 7'b001_0000,
        S_MOVE_RD = 7'b010_0000,
        S_MOVE_WR = 7'b100_0000
    } state_t;

    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);

    state_t            state_reg, state_next;
    logic              place_reg, place_next;
    logic              tbl_reg, tbl_next;
    logic [1:0]        op_reg, op_next;
    logic [31:0]       addr_reg, addr_next;
    logic [31:0]       key_reg, key_next;
    logic [31:0]       size_reg, size_next;
    logic [15:0]       id_reg, id_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  cnt_main_reg, cnt_main_next;
    logic [CNT_W-1:0]  cnt_ovl_reg, cnt_ovl_next;
    response_t         result_reg, result_next;
    logic              done_reg, done_next;

    logic [CNT_W:0]    mid_sum;
    logic [CNT_W-1:0]  mid_val;
    logic [CNT_W-1:0]  lo_dec;
    logic [CNT_W-1:0]  j_dec;
    cmp_res_t          cmp;

    asrl_cmp u_cmp (
        .entry (ram_rdata),
        .key   (key_reg),
        .reach (cfg.unsized_reach),
        .res   (cmp)
    );

    assign mid_sum = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid_val = mid_sum[CNT_W:1];
    assign lo_dec  = lo_reg - 1'b1;
    assign j_dec   = j_reg - 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        place_next    = 1'b0;
        tbl_next      = tbl_reg;
        op_next       = op_reg;
        addr_next     = addr_reg;
        key_next      = key_reg;
        size_next     = size_reg;
        id_next       = id_reg;
        lo_next       = lo_reg;
        hi_next       = hi_reg;
        mid_next      = mid_reg;
        j_next        = j_reg;
        cnt_main_next = cnt_main_reg;
        cnt_ovl_next  = cnt_ovl_reg;
        result_next   = result_reg;
        done_next     = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = {tbl_reg, j_reg[IDX_W-1:0]};
        ram_wdata     = ram_rdata;
        ram_raddr     = {tbl_reg, mid_val[IDX_W-1:0]};

        if (place_reg)
        begin
            ram_we          = 1'b1;
            ram_waddr       = {tbl_reg, lo_reg[IDX_W-1:0]};
            ram_wdata.start  = key_reg;
            ram_wdata.length = size_reg;
            ram_wdata.ident  = ID_BITS'(id_reg);
            if (tbl_reg)
            begin
                cnt_ovl_next = cnt_ovl_reg + 1'b1;
            end
            else
            begin
                cnt_main_next = cnt_main_reg + 1'b1;
            end
            result_next = '{status: ST_DONE, from_overlay: 1'b0,
                            match_id: 16'd0, match_offset: 32'd0};
            done_next   = 1'b1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (start && !place_reg)
                begin
                    op_next   = request.operation;
                    addr_next = request.address;
                    key_next  = request.address;
                    size_next = request.entry_size;
                    id_next   = request.entry_id;
                    lo_next   = '0;
                    case (request.operation)
                        OP_LOOKUP:
                        begin
                            tbl_next = 1'b0;
                            hi_next  = cnt_main_reg;
                            if (request.address == 32'd0)
                            begin
                                result_next = '{status: ST_MISS, from_overlay: 1'b0,
                                                match_id: 16'd0, match_offset: 32'd0};
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        OP_INS_MAIN, OP_INS_OVL:
                        begin
                            tbl_next = (request.operation == OP_INS_OVL);
                            hi_next  = (request.operation == OP_INS_OVL) ?
                                       cnt_ovl_reg : cnt_main_reg;
                            if (hi_next == FULL_CNT)
                            begin
                                result_next = '{status: ST_FULL, from_overlay: 1'b0,
                                                match_id: 16'd0, match_offset: 32'd0};
                                done_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_SRCH;
                            end
                        end
                        default:
                        begin
                            cnt_main_next = '0;
                            cnt_ovl_next  = '0;
                            result_next   = '{status: ST_DONE, from_overlay: 1'b0,
                                              match_id: 16'd0, match_offset: 32'd0};
                            done_next     = 1'b1;
                        end
                    endcase
                end
            end
            S_SRCH:
            begin
                if (lo_reg < hi_reg)
                begin
                    mid_next   = mid_val;
                    state_next = S_CMP;
                end
                else if (op_reg == OP_LOOKUP)
                begin
                    if (lo_reg == '0)
                    begin
                        state_next = tbl_reg ? S_IDLE : S_OVL;
                        if (tbl_reg)
                        begin
                            result_next = '{status: ST_MISS, from_overlay: 1'b0,
                                            match_id: 16'd0, match_offset: 32'd0};
                            done_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        ram_raddr  = {tbl_reg, lo_dec[IDX_W-1:0]};
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    j_next = tbl_reg ? cnt_ovl_reg : cnt_main_reg;
                    if (j_next > lo_reg)
                    begin
                        state_next = S_MOVE_RD;
                    end
                    else
                    begin
                        place_next = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_CMP:
            begin
                if (cmp.le)
                begin
                    lo_next = mid_reg + 1'b1;
                end
                else
                begin
                    hi_next = mid_reg;
                end
                state_next = S_SRCH;
            end
            S_CHECK:
            begin
                if (cmp.hit)
                begin
                    result_next = '{status: ST_MATCH, from_overlay: tbl_reg,
                                    match_id: 16'(ram_rdata.ident),
                                    match_offset: cmp.delta};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else if (tbl_reg)
                begin
                    result_next = '{status: ST_MISS, from_overlay: 1'b0,
                                    match_id: 16'd0, match_offset: 32'd0};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    state_next = S_OVL;
                end
            end
            S_OVL:
            begin
                if (cfg.overlay_text_base != 32'd0 && addr_reg >= cfg.overlay_text_base)
                begin
                    tbl_next   = 1'b1;
                    key_next   = addr_reg - cfg.overlay_text_base;
                    lo_next    = '0;
                    hi_next    = cnt_ovl_reg;
                    state_next = S_SRCH;
                end
                else
                begin
                    result_next = '{status: ST_MISS, from_overlay: 1'b0,
                                    match_id: 16'd0, match_offset: 32'd0};
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            S_MOVE_RD:
            begin
                ram_raddr  = {tbl_reg, j_dec[IDX_W-1:0]};
                state_next = S_MOVE_WR;
            end
            S_MOVE_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = {tbl_reg, j_reg[IDX_W-1:0]};
                ram_wdata = ram_rdata;
                j_next    = j_dec;
                if (j_dec > lo_reg)
                begin
                    state_next = S_MOVE_RD;
                end
                else
                begin
                    place_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            place_reg    <= 1'b0;
            cnt_main_reg <= '0;
            cnt_ovl_reg  <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            place_reg    <= place_next;
            cnt_main_reg <= cnt_main_next;
            cnt_ovl_reg  <= cnt_ovl_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        tbl_reg    <= tbl_next;
        op_reg     <= op_next;
        addr_reg   <= addr_next;
        key_reg    <= key_next;
        size_reg   <= size_next;
        id_reg     <= id_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        mid_reg    <= mid_next;
        j_reg      <= j_next;
        result_reg <= result_next;
    end

    assign busy     = (state_reg != S_IDLE) || place_reg;
    assign done     = done_reg;
    assign response = result_reg;

endmodule

### design/address_symbol_range_lookup_core.sv
// Top level: configuration registers, shared table RAM and lookup sequencer.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+--------------------------------------
//  request   | start && !busy        | request (operation, address, size, id)
//  response  | done, one cycle       | response (status, overlay, id, offset)
//  config    | cfg_valid && cfg_ready| cfg_index, cfg_data
//
//  After the transfer, clear, full and zero-address items give done without a search;
//  a lookup runs a binary search (at most 9 steps per table) and a range check,
//  and may retry in the overlay table when the main table misses; an insert runs
//  a binary search, shifts the later entries up one by one, then writes the new entry.
//  Reset empties both tables at once through the fill counts.
//  Results cannot be stalled; busy stays high until the result is issued.
module address_symbol_range_lookup_core import asrl_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  request_t    request,
    output logic        done,
    output response_t   response,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);

    cfg_t                 cfg_reg;
    logic                 ram_we;
    logic [RAM_AW-1:0]    ram_waddr;
    logic [RAM_AW-1:0]    ram_raddr;
    entry_t               ram_wdata;
    entry_t               ram_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.overlay_text_base <= 32'd0;
            cfg_reg.unsized_reach     <= REACH_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OVERLAY_BASE:  cfg_reg.overlay_text_base <= cfg_data;
                REG_UNSIZED_REACH: cfg_reg.unsized_reach     <= cfg_data;
                default:           cfg_reg.unsized_reach     <= cfg_data;
            endcase
        end
    end

    asrl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    asrl_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .request   (request),
        .cfg       (cfg_reg),
        .busy      (busy),
        .done      (done),
        .response  (response),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

endmodule

### tb/sv/address_symbol_range_lookup_core_tb.sv
// Self-checking testbench for the address symbol range lookup core.
module address_symbol_range_lookup_core_tb import asrl_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          MAIN_TAB    = 0;
    localparam int          OVL_TAB     = 1;
    localparam int          ITEM_TARGET = 1750;
    localparam int          FILL_CAP    = 64;
    localparam int unsigned CYCLE_LIMIT = 4_000_000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    request_t    request;
    logic        done;
    response_t   response;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [31:0] cfg_data;

    logic [31:0] tab_start  [2][TABLE_ENTRIES];
    logic [31:0] tab_length [2][TABLE_ENTRIES];
    logic [15:0] tab_ident  [2][TABLE_ENTRIES];
    int          tab_fill   [2];
    logic [31:0] overlay_base_shadow;
    logic [31:0] reach_shadow;

    response_t   pending_outcomes[$];
    int          mismatches;
    int          items_sent;
    int          main_hits;
    int          overlay_hits;
    int          dropped_inserts;
    int          register_writes;
    int          gap_max;

    address_symbol_range_lookup_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .request   (request),
        .done      (done),
        .response  (response),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int starts_at_or_below(int t, logic [31:0] key);
        int n = 0;
        for (int i = 0; i < tab_fill[t]; i++)
            if (tab_start[t][i] <= key)
                n++;
        return n;
    endfunction

    function automatic bit probe_table(int t, logic [31:0] key,
                                       output logic [15:0] id, output logic [31:0] off);
        int          pos;
        logic [31:0] s;
        logic [31:0] len;
        logic [31:0] delta;
        id  = '0;
        off = '0;
        pos = starts_at_or_below(t, key);
        if (pos == 0)
            return 1'b0;
        s     = tab_start[t][pos - 1];
        len   = tab_length[t][pos - 1];
        delta = key - s;
        if (len != 0 && ({1'b0, key} >= ({1'b0, s} + {1'b0, len})))
            return 1'b0;
        if (len == 0 && delta > reach_shadow)
            return 1'b0;
        id  = tab_ident[t][pos - 1];
        off = delta;
        return 1'b1;
    endfunction

    function automatic logic [1:0] store_entry(int t, request_t r);
        int pos;
        if (tab_fill[t] >= TABLE_ENTRIES)
            return ST_FULL;
        pos = starts_at_or_below(t, r.address);
        for (int i = tab_fill[t]; i > pos; i--)
        begin
            tab_start[t][i]  = tab_start[t][i - 1];
            tab_length[t][i] = tab_length[t][i - 1];
            tab_ident[t][i]  = tab_ident[t][i - 1];
        end
        tab_start[t][pos]  = r.address;
        tab_length[t][pos] = r.entry_size;
        tab_ident[t][pos]  = r.entry_id;
        tab_fill[t]++;
        return ST_DONE;
    endfunction

    function automatic response_t compute_outcome(request_t r);
        response_t   o;
        logic [15:0] id;
        logic [31:0] off;
        o        = '0;
        o.status = ST_MISS;
        case (op_t'(r.operation))
            OP_LOOKUP:
            begin
                if (r.address != 0)
                begin
                    if (tab_fill[MAIN_TAB] != 0 && probe_table(MAIN_TAB, r.address, id, off))
                    begin
                        o.status       = ST_MATCH;
                        o.match_id     = id;
                        o.match_offset = off;
                    end
                    else if (tab_fill[OVL_TAB] != 0 && overlay_base_shadow != 0 &&
                             r.address >= overlay_base_shadow &&
                             probe_table(OVL_TAB, r.address - overlay_base_shadow, id, off))
                    begin
                        o.status       = ST_MATCH;
                        o.from_overlay = 1'b1;
                        o.match_id     = id;
                        o.match_offset = off;
                    end
                end
            end
            OP_INS_MAIN: o.status = store_entry(MAIN_TAB, r);
            OP_INS_OVL:  o.status = store_entry(OVL_TAB, r);
            default:
            begin
                tab_fill[MAIN_TAB] = 0;
                tab_fill[OVL_TAB]  = 0;
                o.status           = ST_DONE;
            end
        endcase
        return o;
    endfunction

    function automatic request_t make_item(op_t op, logic [31:0] addr,
                                           logic [31:0] size, logic [15:0] id);
        request_t r;
        r.operation  = op;
        r.address    = addr;
        r.entry_size = size;
        r.entry_id   = id;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("ERROR %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic send_item(request_t item);
        int        gap;
        response_t o;
        gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start   <= 1'b1;
        request <= item;
        do @(posedge clk); while (busy);
        o = compute_outcome(item);
        pending_outcomes.push_back(o);
        items_sent++;
        if (o.status == ST_MATCH && o.from_overlay)
            overlay_hits++;
        else if (o.status == ST_MATCH)
            main_hits++;
        else if (o.status == ST_FULL)
            dropped_inserts++;
        @(negedge clk);
    endtask

    task automatic drain_outcomes();
        start <= 1'b0;
        do @(negedge clk); while (pending_outcomes.size() != 0);
    endtask

    task automatic write_register(cfg_reg_t idx, logic [31:0] value);
        drain_outcomes();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_OVERLAY_BASE)
            overlay_base_shadow = value;
        else
            reach_shadow = value;
        register_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        response_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
                report_mismatch("result with nothing pending", response.match_offset, '0);
            else
            begin
                want = pending_outcomes.pop_front();
                if (response.status != want.status)
                    report_mismatch("status", 32'(response.status), 32'(want.status));
                if (response.from_overlay != want.from_overlay)
                    report_mismatch("from_overlay", 32'(response.from_overlay),
                                    32'(want.from_overlay));
                if (response.match_id != want.match_id)
                    report_mismatch("match_id", 32'(response.match_id), 32'(want.match_id));
                if (response.match_offset != want.match_offset)
                    report_mismatch("match_offset", response.match_offset, want.match_offset);
            end
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("address_symbol_range_lookup_core_tb failed");
        $finish;
    end

    task automatic test_empty_and_zero();
        send_item(make_item(OP_LOOKUP, 32'h0, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(make_item(OP_INS_MAIN, 32'h0, 32'h0, 16'h0003));
        send_item(make_item(OP_LOOKUP, 32'h0, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h1, 32'h0, 16'h0));
    endtask

    task automatic test_main_ranges();
        send_item(make_item(OP_INS_MAIN, 32'h0000_1000, 32'h100, 16'hFFFF));
        send_item(make_item(OP_INS_MAIN, 32'h0000_1000, 32'h0, 16'h0001));
        send_item(make_item(OP_LOOKUP, 32'h0000_2000, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h0000_2001, 32'h0, 16'h0));
        send_item(make_item(OP_INS_MAIN, 32'h0000_5000, 32'h10, 16'h0002));
        send_item(make_item(OP_LOOKUP, 32'h0000_500F, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h0000_5010, 32'h0, 16'h0));
        send_item(make_item(OP_INS_MAIN, 32'hFFFF_FF00, 32'hFFFF_FFFF, 16'h8000));
        send_item(make_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0));
    endtask

    task automatic test_overlay_retry();
        write_register(REG_OVERLAY_BASE, 32'h8000_0000);
        send_item(make_item(OP_INS_OVL, 32'h10, 32'h20, 16'h1234));
        send_item(make_item(OP_LOOKUP, 32'h8000_0010, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h7FFF_FFFF, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h8000_0030, 32'h0, 16'h0));
        send_item(make_item(OP_CLEAR, 32'h0, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h1, 32'h0, 16'h0));
    endtask

    task automatic test_reach_extremes();
        write_register(REG_UNSIZED_REACH, 32'h0);
        send_item(make_item(OP_INS_MAIN, 32'h100, 32'h0, 16'h0007));
        send_item(make_item(OP_LOOKUP, 32'h100, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h101, 32'h0, 16'h0));
        write_register(REG_UNSIZED_REACH, 32'hFFFF_FFFF);
        send_item(make_item(OP_LOOKUP, 32'hFFFF_FFFE, 32'h0, 16'h0));
        write_register(REG_OVERLAY_BASE, 32'hFFFF_FFFF);
        write_register(REG_UNSIZED_REACH, 32'h0);
        send_item(make_item(OP_INS_OVL, 32'h0, 32'h0, 16'h0009));
        send_item(make_item(OP_LOOKUP, 32'hFFFF_FFFF, 32'h0, 16'h0));
        send_item(make_item(OP_CLEAR, 32'h0, 32'h0, 16'h0));
        write_register(REG_UNSIZED_REACH, REACH_RESET);
        write_register(REG_OVERLAY_BASE, 32'h0);
    endtask

    task automatic test_full_tables();
        gap_max = 3;
        write_register(REG_OVERLAY_BASE, 32'h4000_0000);
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_item(make_item(OP_INS_MAIN, 32'h100 * (i + 1), 32'h80, 16'(i)));
        send_item(make_item(OP_INS_MAIN, 32'h50, 32'h10, 16'hABCD));
        for (int i = 0; i < TABLE_ENTRIES; i++)
            send_item(make_item(OP_INS_OVL, 32'h100 * (i + 1), 32'h0, 16'(i + 16'h100)));
        send_item(make_item(OP_INS_OVL, 32'h50, 32'h0, 16'h5432));
        send_item(make_item(OP_LOOKUP, 32'h0001_0040, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h0000_0050, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h4000_8050, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h4001_0FFF, 32'h0, 16'h0));
        send_item(make_item(OP_CLEAR, 32'h0, 32'h0, 16'h0));
        send_item(make_item(OP_LOOKUP, 32'h0001_0040, 32'h0, 16'h0));
    endtask

    task automatic test_random_traffic();
        logic [31:0] region;
        logic [31:0] ovl_region;
        logic [31:0] addr;
        logic [31:0] size;
        logic [31:0] span;
        int          ops;
        int          pick;
        int          t;
        int          idx;
        while (items_sent < ITEM_TARGET)
        begin
            case ($urandom_range(0, 3))
                0:       write_register(REG_OVERLAY_BASE, 32'h0);
                1:       write_register(REG_OVERLAY_BASE, 32'hFFFF_FFFF);
                2:       write_register(REG_OVERLAY_BASE, $urandom);
                default: write_register(REG_OVERLAY_BASE, {4'($urandom_range(1, 15)), 28'h0});
            endcase
            case ($urandom_range(0, 4))
                0:       write_register(REG_UNSIZED_REACH, 32'h0);
                1:       write_register(REG_UNSIZED_REACH, 32'hFFFF_FFFF);
                2:       write_register(REG_UNSIZED_REACH, REACH_RESET);
                3:       write_register(REG_UNSIZED_REACH, $urandom_range(1, 32'h4000));
                default: write_register(REG_UNSIZED_REACH, $urandom);
            endcase
            gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 15;
            region     = $urandom;
            ovl_region = $urandom_range(0, 32'hFFFF);
            if ($urandom_range(0, 2) == 0 || tab_fill[MAIN_TAB] > FILL_CAP ||
                tab_fill[OVL_TAB] > FILL_CAP)
                send_item(make_item(OP_CLEAR, $urandom, $urandom, 16'($urandom)));
            ops = $urandom_range(20, 60);
            for (int n = 0; n < ops; n++)
            begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0, 1, 2: size = 32'h0;
                    8, 9:    size = $urandom;
                    default: size = $urandom_range(1, 32'h1000);
                endcase
                if (pick < 35)
                begin
                    t    = (pick < 25) ? MAIN_TAB : OVL_TAB;
                    addr = ((t == MAIN_TAB) ? region : ovl_region) + $urandom_range(0, 32'h3_FFFF);
                    if (tab_fill[t] != 0 && $urandom_range(0, 4) == 0)
                        addr = tab_start[t][$urandom_range(0, tab_fill[t] - 1)];
                    send_item(make_item((t == MAIN_TAB) ? OP_INS_MAIN : OP_INS_OVL,
                                        addr, size, 16'($urandom)));
                end
                else if (pick < 90)
                begin
                    t = ($urandom_range(0, 2) == 0) ? OVL_TAB : MAIN_TAB;
                    if (tab_fill[t] != 0)
                    begin
                        idx  = $urandom_range(0, tab_fill[t] - 1);
                        span = (tab_length[t][idx] != 0) ? tab_length[t][idx] : reach_shadow;
                        if (span > 32'h1_0000)
                            span = 32'h1_0000;
                        addr = tab_start[t][idx] + $urandom_range(0, span + span / 8 + 2);
                        if (t == OVL_TAB)
                            addr = addr + overlay_base_shadow;
                    end
                    else
                        addr = $urandom;
                    send_item(make_item(OP_LOOKUP, addr, $urandom, 16'($urandom)));
                end
                else
                    send_item(make_item(op_t'($urandom_range(0, 3)), $urandom, $urandom,
                                        16'($urandom)));
            end
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        start               = 1'b0;
        request             = '0;
        cfg_valid           = 1'b0;
        cfg_index           = 1'b0;
        cfg_data            = '0;
        tab_fill[MAIN_TAB]  = 0;
        tab_fill[OVL_TAB]   = 0;
        overlay_base_shadow = '0;
        reach_shadow        = REACH_RESET;
        mismatches          = 0;
        items_sent          = 0;
        main_hits           = 0;
        overlay_hits        = 0;
        dropped_inserts     = 0;
        register_writes     = 0;
        gap_max             = 15;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_and_zero();
        test_main_ranges();
        test_overlay_retry();
        test_reach_extremes();
        test_full_tables();
        test_random_traffic();

        drain_outcomes();
        repeat (64) @(negedge clk);
        if (pending_outcomes.size() != 0)
            report_mismatch("results never seen", 32'(pending_outcomes.size()), '0);
        $display("Run covered %0d request transfers: %0d main hits, %0d overlay hits, %0d drops",
                 items_sent, main_hits, overlay_hits, dropped_inserts);
        $display("Register writes %0d, mismatches %0d", register_writes, mismatches);
        if (mismatches == 0)
            $display("address_symbol_range_lookup_core_tb passed");
        else
            $display("address_symbol_range_lookup_core_tb failed");
        $finish;
    end

endmodule

### filelist.f
design/asrl_pkg.sv
design/asrl_ram.sv
design/asrl_cmp.sv
design/asrl_seq.sv
design/address_symbol_range_lookup_core.sv
tb/sv/address_symbol_range_lookup_core_tb.sv
